// ===== rtl/nlpt_pkg.sv =====
// Shared constants, register codes and controller/datapath interface types
// for the next-line prefetch tracker. No dependencies.
package nlpt_pkg;

  localparam int TRACKER_DEPTH    = 64;
  localparam int LOG2_BLOCK_BYTES = 6;
  localparam int LOG2_PAGE_BYTES  = 12;

  localparam int ADDR_W     = 64;
  localparam int DELTA_W    = 7;
  localparam int LIMIT_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int CLASS_W    = 2;

  localparam int BLOCKS_W = LOG2_PAGE_BYTES - LOG2_BLOCK_BYTES;
  localparam int TGT_W    = ((BLOCKS_W > DELTA_W) ? BLOCKS_W : DELTA_W) + 2;
  localparam int SLOT_W   = (TRACKER_DEPTH > 1) ? $clog2(TRACKER_DEPTH) : 1;
  localparam int CNT_W    = $clog2(TRACKER_DEPTH + 1);
  // Tracker entry: {address, filled flag, timeliness class}.
  localparam int ENTRY_W  = ADDR_W + 1 + CLASS_W;

  localparam logic [CLASS_W-1:0] CLASS_TIMELY   = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_UNTIMELY = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_NEVER    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_DELTA      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRACKER_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRACKING_ENABLE = 2'd2;

  localparam logic OP_DEMAND = 1'b0;
  localparam logic OP_FILL   = 1'b1;

  typedef struct packed {
    logic accept;
    logic scan_issue;
    logic upd_write;
    logic ins_write;
    logic out_load;
  } nlpt_cmd_t;

  typedef struct packed {
    logic track;
    logic cnt_zero;
    logic scan_last;
  } nlpt_status_t;

endpackage

// ===== rtl/nlpt_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module nlpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/nlpt_ctrl.sv =====
// Sequencing state machine of the prefetch tracker: accept, tracker scan,
// entry update, insertion and result hand-off. Depends on nlpt_pkg.
module nlpt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  nlpt_pkg::nlpt_status_t status,
  output nlpt_pkg::nlpt_cmd_t    cmd
);
  import nlpt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_SCAN, S_TAIL, S_UPD, S_INS, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_START;
      S_START: begin
        if (!status.track) begin
          state_nxt = S_FIN;
        end else if (status.cnt_zero) begin
          state_nxt = S_UPD;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN:  if (status.scan_last) state_nxt = S_TAIL;
      S_TAIL:  state_nxt = S_UPD;
      S_UPD:   state_nxt = S_INS;
      S_INS:   state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.accept     = (state_r == S_IDLE) && in_valid;
    cmd.scan_issue = (state_r == S_SCAN);
    cmd.upd_write  = (state_r == S_UPD);
    cmd.ins_write  = (state_r == S_INS);
    cmd.out_load   = (state_r == S_FIN) && out_free;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/nlpt_dpath.sv =====
// Datapath of the prefetch tracker: configuration registers, target block
// arithmetic, FIFO pointers, tracker RAM scan and result registers.
// Depends on nlpt_pkg and nlpt_ram.
module nlpt_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_operation,
  input  logic [nlpt_pkg::ADDR_W-1:0]       in_address,
  input  logic                              cfg_valid,
  input  logic [nlpt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nlpt_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  nlpt_pkg::nlpt_cmd_t               cmd,
  output nlpt_pkg::nlpt_status_t            status,
  output logic                              out_prefetch_valid,
  output logic [nlpt_pkg::ADDR_W-1:0]       out_prefetch_address,
  output logic                              out_out_of_page,
  output logic                              out_evicted_valid,
  output logic [nlpt_pkg::CLASS_W-1:0]      out_evicted_class
);
  import nlpt_pkg::*;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    if (s == SLOT_W'(TRACKER_DEPTH - 1)) begin
      return '0;
    end
    return s + SLOT_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] eff_limit(input logic [LIMIT_W-1:0] lim);
    if (lim == '0) begin
      return CNT_W'(1);
    end
    if (int'(lim) > TRACKER_DEPTH) begin
      return CNT_W'(TRACKER_DEPTH);
    end
    return CNT_W'(lim);
  endfunction

  // Configuration.
  logic signed [DELTA_W-1:0] delta_r;
  logic [LIMIT_W-1:0]        limit_r;
  logic                      track_r;

  // Current item.
  logic              op_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] pf_addr_r;
  logic              in_page_r;

  // FIFO pointers and scan.
  logic [SLOT_W-1:0] oldest_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  scan_idx_r;
  logic [SLOT_W-1:0] rd_slot_r;
  logic              cmp_valid_r;
  logic              cmp_first_r;
  logic [SLOT_W-1:0] cmp_slot_r;

  // Scan results.
  logic               hit_r;
  logic               pf_present_r;
  logic [SLOT_W-1:0]  hit_slot_r;
  logic               hit_filled_r;
  logic [CLASS_W-1:0] hit_tl_r;
  logic [CLASS_W-1:0] oldest_tl_r;
  logic               ev_valid_r;
  logic [CLASS_W-1:0] ev_class_r;

  // Result registers.
  logic               res_pf_valid_r;
  logic [ADDR_W-1:0]  res_pf_addr_r;
  logic               res_oop_r;
  logic               res_ev_valid_r;
  logic [CLASS_W-1:0] res_ev_class_r;

  // Target block from the incoming address.
  logic [BLOCKS_W-1:0]     offset;
  logic signed [TGT_W-1:0] target;
  logic                    target_in_page;
  logic [ADDR_W-1:0]       target_addr;

  assign offset = in_address[LOG2_PAGE_BYTES-1:LOG2_BLOCK_BYTES];
  assign target = $signed({{(TGT_W - BLOCKS_W){1'b0}}, offset})
                + $signed({{(TGT_W - DELTA_W){delta_r[DELTA_W-1]}}, delta_r});
  assign target_in_page = (target[TGT_W-1:BLOCKS_W] == '0);
  assign target_addr = {in_address[ADDR_W-1:LOG2_PAGE_BYTES], target[BLOCKS_W-1:0],
                        {LOG2_BLOCK_BYTES{1'b0}}};

  // Tracker RAM.
  logic               ram_wr_en;
  logic [SLOT_W-1:0]  ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic [ENTRY_W-1:0] ram_rd_data;
  logic [ADDR_W-1:0]  rd_entry_addr;
  logic               rd_entry_filled;
  logic [CLASS_W-1:0] rd_entry_tl;

  assign rd_entry_addr   = ram_rd_data[ENTRY_W-1:CLASS_W+1];
  assign rd_entry_filled = ram_rd_data[CLASS_W];
  assign rd_entry_tl     = ram_rd_data[CLASS_W-1:0];

  nlpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TRACKER_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.scan_issue),
    .rd_addr (rd_slot_r),
    .rd_data (ram_rd_data)
  );

  // Update and insertion decisions.
  logic [CLASS_W-1:0] new_tl;
  logic               do_update;
  logic               need_insert;
  logic               do_insert;
  logic               evict_now;
  logic [CNT_W:0]     ins_sum;
  logic [SLOT_W-1:0]  ins_slot;
  logic [CLASS_W-1:0] evict_class;

  assign new_tl      = hit_filled_r ? CLASS_TIMELY : CLASS_UNTIMELY;
  assign do_update   = cmd.upd_write && hit_r;
  assign need_insert = (op_r == OP_DEMAND) && track_r && in_page_r && !pf_present_r;
  assign do_insert   = cmd.ins_write && need_insert;
  assign evict_now   = (count_r >= eff_limit(limit_r));
  assign ins_sum     = {1'b0, count_r} + (CNT_W + 1)'(oldest_r);

  always_comb begin
    if (ins_sum >= (CNT_W + 1)'(TRACKER_DEPTH)) begin
      ins_slot = SLOT_W'(ins_sum - (CNT_W + 1)'(TRACKER_DEPTH));
    end else begin
      ins_slot = SLOT_W'(ins_sum);
    end
  end

  // The oldest entry may be the one this demand just classified.
  always_comb begin
    if (hit_r && (op_r == OP_DEMAND) && (hit_slot_r == oldest_r)) begin
      evict_class = new_tl;
    end else begin
      evict_class = oldest_tl_r;
    end
  end

  always_comb begin
    ram_wr_en   = do_update || do_insert;
    ram_wr_addr = ins_slot;
    ram_wr_data = {pf_addr_r, 1'b0, CLASS_NEVER};
    if (do_update) begin
      // A hit entry holds exactly the item's address.
      ram_wr_addr = hit_slot_r;
      if (op_r == OP_FILL) begin
        ram_wr_data = {addr_r, 1'b1, hit_tl_r};
      end else begin
        ram_wr_data = {addr_r, hit_filled_r, new_tl};
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_r <= DELTA_W'(1);
      limit_r <= LIMIT_W'(64);
      track_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LINE_DELTA:      delta_r <= $signed(cfg_data[DELTA_W-1:0]);
        REG_TRACKER_LIMIT:   limit_r <= cfg_data[LIMIT_W-1:0];
        REG_TRACKING_ENABLE: track_r <= cfg_data[0];
        default:             ;
      endcase
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r      <= in_operation;
      addr_r    <= in_address;
      pf_addr_r <= target_addr;
      in_page_r <= target_in_page;
    end
  end

  // Pointers, scan control and flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r     <= '0;
      count_r      <= '0;
      scan_idx_r   <= '0;
      rd_slot_r    <= '0;
      cmp_valid_r  <= 1'b0;
      hit_r        <= 1'b0;
      pf_present_r <= 1'b0;
      ev_valid_r   <= 1'b0;
    end else begin
      cmp_valid_r <= cmd.scan_issue;
      if (cmd.accept) begin
        scan_idx_r   <= '0;
        rd_slot_r    <= oldest_r;
        hit_r        <= 1'b0;
        pf_present_r <= 1'b0;
        ev_valid_r   <= 1'b0;
      end
      if (cmd.scan_issue) begin
        scan_idx_r <= scan_idx_r + CNT_W'(1);
        rd_slot_r  <= slot_inc(rd_slot_r);
      end
      if (cmp_valid_r) begin
        if (!hit_r && (rd_entry_addr == addr_r)) begin
          hit_r <= 1'b1;
        end
        if (rd_entry_addr == pf_addr_r) begin
          pf_present_r <= 1'b1;
        end
      end
      if (do_insert) begin
        ev_valid_r <= evict_now;
        if (evict_now) begin
          oldest_r <= slot_inc(oldest_r);
        end else begin
          count_r <= count_r + CNT_W'(1);
        end
      end
    end
  end

  // Scan payload captures.
  always_ff @(posedge clk) begin
    if (cmd.scan_issue) begin
      cmp_first_r <= (scan_idx_r == '0);
      cmp_slot_r  <= rd_slot_r;
    end
    if (cmp_valid_r) begin
      if (!hit_r && (rd_entry_addr == addr_r)) begin
        hit_slot_r   <= cmp_slot_r;
        hit_filled_r <= rd_entry_filled;
        hit_tl_r     <= rd_entry_tl;
      end
      if (cmp_first_r) begin
        oldest_tl_r <= rd_entry_tl;
      end
    end
    if (do_insert) begin
      ev_class_r <= evict_class;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_pf_valid_r <= (op_r == OP_DEMAND) && in_page_r;
      res_pf_addr_r  <= ((op_r == OP_DEMAND) && in_page_r) ? pf_addr_r : '0;
      res_oop_r      <= (op_r == OP_DEMAND) && !in_page_r;
      res_ev_valid_r <= ev_valid_r;
      res_ev_class_r <= ev_valid_r ? ev_class_r : CLASS_TIMELY;
    end
  end

  assign status.track     = track_r;
  assign status.cnt_zero  = (count_r == '0);
  assign status.scan_last = (scan_idx_r == (count_r - CNT_W'(1)));

  assign out_prefetch_valid   = res_pf_valid_r;
  assign out_prefetch_address = res_pf_addr_r;
  assign out_out_of_page      = res_oop_r;
  assign out_evicted_valid    = res_ev_valid_r;
  assign out_evicted_class    = res_ev_class_r;

endmodule

// ===== rtl/next_line_prefetch_tracker_top.sv =====
// Top level of the next-line prefetch tracker: joins the controller and the
// datapath. Depends on nlpt_pkg, nlpt_ctrl, nlpt_dpath (and nlpt_ram below it).
//
// Usage. Each input item is either a demand access or a cache fill notice,
// with its byte address. Every item returns exactly one result item: for a
// demand, the block-aligned next-line prefetch (or an out-of-page flag) and,
// if the prefetch evicted a tracker entry, that entry's class. Configuration
// (delta, tracker limit, tracking enable) is written through the cfg_ channel,
// which is always ready, by the user only while the block is idle (unenforced).
//
// Sequence. With tracking off, an accepted item goes straight to its result
// hand-off. With tracking on, it first scans the live tracker entries (no
// scan for an empty tracker). The tracker RAM has a single read port, so the
// lookup reads one entry per cycle; a tail step then takes the last read, an
// update step rewrites a hit entry and an insertion step inserts the new
// prefetch before the hand-off. A new item is accepted only once the block
// is back in idle, after the hand-off of the current one.
//
// A finished result waits in the output register; a new item is accepted
// meanwhile, and it is only held at its last step if the receiver is still
// stalling. Reset empties the tracker (its RAM needs no clearing pass) and
// restores delta 1, limit 64, tracking off.
module next_line_prefetch_tracker_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic [nlpt_pkg::ADDR_W-1:0]       in_address,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_prefetch_valid,
  output logic [nlpt_pkg::ADDR_W-1:0]       out_prefetch_address,
  output logic                              out_out_of_page,
  output logic                              out_evicted_valid,
  output logic [nlpt_pkg::CLASS_W-1:0]      out_evicted_class,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nlpt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nlpt_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import nlpt_pkg::*;

  nlpt_cmd_t    cmd;
  nlpt_status_t status;

  // Register writes complete in the cycle they are presented.
  assign cfg_ready = 1'b1;

  nlpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  nlpt_dpath u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_operation         (in_operation),
    .in_address           (in_address),
    .cfg_valid            (cfg_valid),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .cmd                  (cmd),
    .status               (status),
    .out_prefetch_valid   (out_prefetch_valid),
    .out_prefetch_address (out_prefetch_address),
    .out_out_of_page      (out_out_of_page),
    .out_evicted_valid    (out_evicted_valid),
    .out_evicted_class    (out_evicted_class)
  );

endmodule

// ===== rtl/nlpt_checker.sv =====
// Port-level assertions for the next-line prefetch tracker, bound to the top
// level. Depends on nlpt_pkg and next_line_prefetch_tracker_top.
module nlpt_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_prefetch_valid,
  input logic [nlpt_pkg::ADDR_W-1:0]       out_prefetch_address,
  input logic                              out_out_of_page,
  input logic                              out_evicted_valid,
  input logic [nlpt_pkg::CLASS_W-1:0]      out_evicted_class
);
  import nlpt_pkg::*;

  // A stalled result keeps its prefetch address and eviction fields.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_prefetch_address)
      && $stable(out_evicted_valid) && $stable(out_evicted_class))
    else $error("result changed while stalled");

  // The controller leaves idle once an item is accepted, so acceptance closes the input.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // A result is either an in-page prefetch, an out-of-page demand, or a fill.
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_prefetch_valid && out_out_of_page)
      && (out_prefetch_valid || out_prefetch_address == '0))
    else $error("inconsistent prefetch fields");

  // Eviction only comes from an insertion, which needs an issued prefetch.
  a_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted_valid |-> out_prefetch_valid
      && (out_evicted_class == CLASS_TIMELY || out_evicted_class == CLASS_UNTIMELY
          || out_evicted_class == CLASS_NEVER))
    else $error("bad eviction report");

  a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_prefetch_valid |->
      out_prefetch_address[LOG2_BLOCK_BYTES-1:0] == '0)
    else $error("prefetch address not block aligned");

endmodule

bind next_line_prefetch_tracker_top nlpt_checker u_nlpt_checker (.*);
